FILE: hdl/slbm_pkg.sv
// slbm_pkg: shared types and constants for the serial-loaded bank mapper
// used by slbm_core, serial_loaded_bank_mapper and slbm_chk; no dependencies
`timescale 1ns / 1ps

package slbm_pkg;

  localparam int unsigned AddrW   = 16;
  localparam int unsigned DataW   = 8;
  localparam int unsigned OffsetW = 18;
  localparam int unsigned PrgCntW = 5;
  localparam int unsigned ChrCntW = 6;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  localparam logic [PrgCntW-1:0] PrgCountReset = 5'd16;
  localparam logic [ChrCntW-1:0] ChrCountReset = 6'd0;
  localparam logic [4:0] ControlReset = 5'h1C;
  localparam logic [4:0] PrgModeForce = 5'h0C;

  typedef enum logic [1:0] {
    CMD_CPU_READ  = 2'd0,
    CMD_CPU_WRITE = 2'd1,
    CMD_PPU_READ  = 2'd2,
    CMD_UNUSED    = 2'd3
  } slbm_cmd_e;

  typedef enum logic [2:0] {
    TGT_NONE    = 3'd0,
    TGT_PRG_ROM = 3'd1,
    TGT_PRG_RAM = 3'd2,
    TGT_CHR_ROM = 3'd3,
    TGT_CHR_RAM = 3'd4
  } slbm_target_e;

  // loader register select, address bits 14..13
  typedef enum logic [1:0] {
    SEL_CONTROL = 2'd0,
    SEL_CHR0    = 2'd1,
    SEL_CHR1    = 2'd2,
    SEL_PRG     = 2'd3
  } slbm_sel_e;

  // configuration register index, paddr bit 2
  typedef enum logic {
    REG_PRG_COUNT = 1'b0,
    REG_CHR_COUNT = 1'b1
  } slbm_reg_e;

  typedef struct packed {
    logic [PrgCntW-1:0] prg_bank_count;
    logic [ChrCntW-1:0] chr_bank_count;
  } slbm_cfg_t;

  typedef struct packed {
    slbm_target_e        target;
    logic [OffsetW-1:0]  offset;
  } slbm_result_t;

endpackage

FILE: hdl/serial_loaded_bank_mapper.sv
// serial_loaded_bank_mapper: top level with config registers and result register
// depends on slbm_pkg and slbm_core
`timescale 1ns / 1ps

// Cartridge bank mapper. Each bus access enters on the input channel
// (in_valid_i/in_ready_o with cmd_i, bus_address_i, write_data_i) and
// yields exactly one item on the output channel (out_valid_o/out_ready_i
// with target_o, offset_o): the memory the access maps to and the byte
// offset inside it. CPU writes at 0x8000 and up feed the serial loader
// and always report no target.
// The result is registered: an accepted item is shown in the cycle after it
// is accepted. Throughput is one item per cycle while the receiver takes
// each result; translation is a single level of decode and bank concatenation
// into the result register. A stalled receiver holds the result register; a
// new item is still taken in the cycle the held one is taken. in_ready_o is
// low only while a result waits and out_ready_i is low.
// Reset clears the output valid, the loader, and loads the control register
// with 16k mode, last bank fixed; prg_bank_count resets to 16, chr_bank_count
// to 0 (CHR RAM). Config is written on the APB port at 0x0 (prg_bank_count)
// and 0x4 (chr_bank_count); the user must write only while idle (unenforced).

module serial_loaded_bank_mapper (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        cmd_i,
  input  logic [slbm_pkg::AddrW-1:0]        bus_address_i,
  input  logic [slbm_pkg::DataW-1:0]        write_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [2:0]                        target_o,
  output logic [slbm_pkg::OffsetW-1:0]      offset_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [slbm_pkg::ApbAddrW-1:0]     paddr,
  input  logic [slbm_pkg::ApbDataW-1:0]     pwdata,
  output logic [slbm_pkg::ApbDataW-1:0]     prdata,
  output logic                              pready
);
  import slbm_pkg::*;

  slbm_cfg_t    cfg_q, cfg_d;
  slbm_result_t result;
  slbm_result_t result_q;
  logic         out_valid_q, out_valid_d;
  logic         accept;
  slbm_reg_e    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = slbm_reg_e'(paddr[2]);

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_PRG_COUNT: cfg_d.prg_bank_count = pwdata[PrgCntW-1:0];
        REG_CHR_COUNT: cfg_d.chr_bank_count = pwdata[ChrCntW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PRG_COUNT: prdata = {{(ApbDataW-PrgCntW){1'b0}}, cfg_q.prg_bank_count};
      REG_CHR_COUNT: prdata = {{(ApbDataW-ChrCntW){1'b0}}, cfg_q.chr_bank_count};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prg_bank_count <= PrgCountReset;
      cfg_q.chr_bank_count <= ChrCountReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  slbm_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .cmd_i    (slbm_cmd_e'(cmd_i)),
    .addr_i   (bus_address_i),
    .data_i   (write_data_i),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign target_o    = result_q.target;
  assign offset_o    = result_q.offset;

endmodule

FILE: hdl/slbm_core.sv
// slbm_core: serial loader, bank registers and address translation
// depends on slbm_pkg
`timescale 1ns / 1ps

module slbm_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  slbm_pkg::slbm_cmd_e           cmd_i,
  input  logic [slbm_pkg::AddrW-1:0]    addr_i,
  input  logic [slbm_pkg::DataW-1:0]    data_i,
  input  slbm_pkg::slbm_cfg_t           cfg_i,
  output slbm_pkg::slbm_result_t        result_o
);
  import slbm_pkg::*;

  logic [4:0] shift_value_q, shift_value_d;
  logic [2:0] shift_count_q, shift_count_d;
  logic [4:0] control_q, control_d;
  logic       chr_four_k_q, chr_four_k_d;
  logic [3:0] prg_bank16_q, prg_bank16_d;
  logic [2:0] prg_bank32_q, prg_bank32_d;
  logic [4:0] chr_low_q, chr_low_d;
  logic [4:0] chr_high_q, chr_high_d;
  logic [3:0] chr_eight_q, chr_eight_d;

  logic [4:0] shifted;
  logic [3:0] last_bank;
  logic [3:0] bank16;
  logic [4:0] chr_bank4;
  slbm_sel_e  sel;

  always_comb begin
    shift_value_d = shift_value_q;
    shift_count_d = shift_count_q;
    control_d     = control_q;
    chr_four_k_d  = chr_four_k_q;
    prg_bank16_d  = prg_bank16_q;
    prg_bank32_d  = prg_bank32_q;
    chr_low_d     = chr_low_q;
    chr_high_d    = chr_high_q;
    chr_eight_d   = chr_eight_q;
    shifted       = {data_i[0], shift_value_q[4:1]};
    sel           = slbm_sel_e'(addr_i[14:13]);
    if (accept_i && cmd_i == CMD_CPU_WRITE && addr_i[15]) begin
      if (data_i[7]) begin
        shift_value_d = '0;
        shift_count_d = '0;
        control_d     = control_q | PrgModeForce;
      end else if (shift_count_q >= 3'd4) begin
        // fifth bit completes the value
        shift_value_d = '0;
        shift_count_d = '0;
        case (sel)
          SEL_CONTROL: begin
            control_d    = shifted;
            chr_four_k_d = shifted[4];
          end
          SEL_CHR0: begin
            if (chr_four_k_q) chr_low_d = shifted;
            else chr_eight_d = shifted[4:1];
          end
          SEL_CHR1: begin
            if (chr_four_k_q) chr_high_d = shifted;
          end
          SEL_PRG: begin
            if (control_q[3]) prg_bank16_d = shifted[3:0];
            else prg_bank32_d = shifted[3:1];
          end
          default: ;
        endcase
      end else begin
        shift_value_d = shifted;
        shift_count_d = shift_count_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_value_q <= '0;
      shift_count_q <= '0;
      control_q     <= ControlReset;
      chr_four_k_q  <= 1'b0;
      prg_bank16_q  <= '0;
      prg_bank32_q  <= '0;
      chr_low_q     <= '0;
      chr_high_q    <= '0;
      chr_eight_q   <= '0;
    end else begin
      shift_value_q <= shift_value_d;
      shift_count_q <= shift_count_d;
      control_q     <= control_d;
      chr_four_k_q  <= chr_four_k_d;
      prg_bank16_q  <= prg_bank16_d;
      prg_bank32_q  <= prg_bank32_d;
      chr_low_q     <= chr_low_d;
      chr_high_q    <= chr_high_d;
      chr_eight_q   <= chr_eight_d;
    end
  end

  // fixed bank is the last one, count clamped to 1..16
  always_comb begin
    if (cfg_i.prg_bank_count == '0) last_bank = 4'd0;
    else if (cfg_i.prg_bank_count >= PrgCountReset) last_bank = 4'd15;
    else last_bank = cfg_i.prg_bank_count[3:0] - 4'd1;
  end

  always_comb begin
    result_o.target = TGT_NONE;
    result_o.offset = '0;
    bank16          = '0;
    chr_bank4       = addr_i[12] ? chr_high_q : chr_low_q;
    case (cmd_i)
      CMD_CPU_READ: begin
        if (addr_i[15:13] == 3'b011) begin
          result_o.target = TGT_PRG_RAM;
          result_o.offset = {5'd0, addr_i[12:0]};
        end else if (addr_i[15]) begin
          result_o.target = TGT_PRG_ROM;
          if (control_q[3]) begin
            if (control_q[2]) bank16 = addr_i[14] ? last_bank : prg_bank16_q;
            else bank16 = addr_i[14] ? prg_bank16_q : 4'd0;
            result_o.offset = {bank16, addr_i[13:0]};
          end else begin
            result_o.offset = {prg_bank32_q, addr_i[14:0]};
          end
        end
      end
      CMD_PPU_READ: begin
        if (addr_i[15:13] == 3'b000) begin
          if (cfg_i.chr_bank_count == '0) begin
            result_o.target = TGT_CHR_RAM;
            result_o.offset = {5'd0, addr_i[12:0]};
          end else begin
            result_o.target = TGT_CHR_ROM;
            if (chr_four_k_q) result_o.offset = {1'b0, chr_bank4, addr_i[11:0]};
            else result_o.offset = {1'b0, chr_eight_q, addr_i[12:0]};
          end
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: hdl/slbm_chk.sv
// slbm_props: port-level checks for serial_loaded_bank_mapper, bound to the top
// depends on slbm_pkg
`timescale 1ns / 1ps

module slbm_props (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [1:0]                        cmd_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [2:0]                        target_i,
  input  logic [slbm_pkg::OffsetW-1:0]      offset_i
);
  import slbm_pkg::*;

  // a result waiting on the receiver stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(target_i) && $stable(offset_i))
    else $error("stalled result changed");

  // every accepted item shows up in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted item produced no result");

  // cpu writes never map to a memory
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && cmd_i == CMD_CPU_WRITE |=> target_i == TGT_NONE)
    else $error("cpu write reported a target");

  // offsets for no target and for prg ram stay inside an 8k window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (target_i == TGT_NONE || target_i == TGT_PRG_RAM)
      |-> offset_i[OffsetW-1:13] == '0)
    else $error("offset outside target window");

endmodule

bind serial_loaded_bank_mapper slbm_props u_slbm_props (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .cmd_i       (cmd_i),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .target_i    (target_o),
  .offset_i    (offset_o)
);
